@@ rtl/assert_macros.svh @@
// Assertion macros used by the queue top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a condition at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// check that a condition holds in the cycle after a trigger
`define ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/fqnf_pkg.sv @@
// Types, codes and microcode program for the negative-filter queue.
package fqnf_pkg;

   localparam int DATA_W        = 32;
   localparam int REQ_W         = 2;
   localparam int STATUS_W      = 2;
   localparam int OCC_W         = 3;
   localparam int STEP_W        = 4;
   localparam int DEPTH_DEFAULT = 6;

   localparam logic [REQ_W-1:0] REQ_ENQ    = 2'd0;
   localparam logic [REQ_W-1:0] REQ_DEQ    = 2'd1;
   localparam logic [REQ_W-1:0] REQ_FILTER = 2'd2;

   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   localparam logic [STEP_W-1:0] STEP_IDLE    = 4'd0;
   localparam logic [STEP_W-1:0] STEP_ENQ     = 4'd1;
   localparam logic [STEP_W-1:0] STEP_DEQ     = 4'd2;
   localparam logic [STEP_W-1:0] STEP_DEQ_TAKE = 4'd3;
   localparam logic [STEP_W-1:0] STEP_FLT     = 4'd4;
   localparam logic [STEP_W-1:0] STEP_FLT_RD  = 4'd5;
   localparam logic [STEP_W-1:0] STEP_FLT_WR  = 4'd6;
   localparam logic [STEP_W-1:0] STEP_FLT_END = 4'd7;
   localparam logic [STEP_W-1:0] STEP_RSP     = 4'd8;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_ACCEPT,
      OP_ENQ,
      OP_DEQ_RD,
      OP_DEQ_TAKE,
      OP_FLT_INIT,
      OP_FLT_RD,
      OP_FLT_WR,
      OP_FLT_END,
      OP_RSP
   } fqnf_op_type;

   typedef enum logic [2:0] {
      COND_NEXT,
      COND_JUMP,
      COND_DISPATCH,
      COND_EMPTY,
      COND_SCAN_DONE,
      COND_RSP_FREE
   } fqnf_cond_type;

   typedef struct packed {
      fqnf_op_type        op;
      fqnf_cond_type      cond;
      logic [STEP_W-1:0]  target;
      logic               take_req;
   } fqnf_ctrl_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic scan_done;
      logic rsp_free;
   } fqnf_flags_type;

   typedef struct packed {
      logic [REQ_W-1:0]         req_type;
      logic signed [DATA_W-1:0] value;
   } fqnf_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic signed [DATA_W-1:0] data;
      logic [OCC_W-1:0]         occupancy;
   } fqnf_rsp_type;

   function automatic fqnf_ctrl_type ucode(input logic [STEP_W-1:0] step);
      fqnf_ctrl_type cw;
      cw = '{op: OP_NOP, cond: COND_JUMP, target: STEP_IDLE, take_req: 1'b0};
      case (step)
         STEP_IDLE: begin
            cw = '{op: OP_ACCEPT, cond: COND_DISPATCH, target: STEP_IDLE, take_req: 1'b1};
         end
         STEP_ENQ: begin
            cw = '{op: OP_ENQ, cond: COND_JUMP, target: STEP_RSP, take_req: 1'b0};
         end
         STEP_DEQ: begin
            cw = '{op: OP_DEQ_RD, cond: COND_EMPTY, target: STEP_RSP, take_req: 1'b0};
         end
         STEP_DEQ_TAKE: begin
            cw = '{op: OP_DEQ_TAKE, cond: COND_JUMP, target: STEP_RSP, take_req: 1'b0};
         end
         STEP_FLT: begin
            cw = '{op: OP_FLT_INIT, cond: COND_NEXT, target: STEP_IDLE, take_req: 1'b0};
         end
         STEP_FLT_RD: begin
            cw = '{op: OP_FLT_RD, cond: COND_SCAN_DONE, target: STEP_FLT_END,
                   take_req: 1'b0};
         end
         STEP_FLT_WR: begin
            cw = '{op: OP_FLT_WR, cond: COND_JUMP, target: STEP_FLT_RD, take_req: 1'b0};
         end
         STEP_FLT_END: begin
            cw = '{op: OP_FLT_END, cond: COND_NEXT, target: STEP_IDLE, take_req: 1'b0};
         end
         STEP_RSP: begin
            cw = '{op: OP_RSP, cond: COND_RSP_FREE, target: STEP_IDLE, take_req: 1'b0};
         end
         default: begin
            cw = '{op: OP_NOP, cond: COND_JUMP, target: STEP_IDLE, take_req: 1'b0};
         end
      endcase
      return cw;
   endfunction

   function automatic logic [STEP_W-1:0] dispatch(input logic [REQ_W-1:0] req_type);
      logic [STEP_W-1:0] step;
      case (req_type)
         REQ_ENQ:    step = STEP_ENQ;
         REQ_DEQ:    step = STEP_DEQ;
         REQ_FILTER: step = STEP_FLT;
         default:    step = STEP_RSP;
      endcase
      return step;
   endfunction

endpackage

@@ rtl/fifo_queue_negative_filter_core.sv @@
// Top level of the bounded queue with a remove-negatives request.
// A transaction on the req_ channel enqueues, dequeues or drops every negative
// entry; each gives exactly one transaction on the rsp_ channel, held in an
// output register so the next request can be taken while it waits. A small
// microcode program steps a 1R1W entry store: an enqueue writes its entry, a
// dequeue reads the head and then takes it unless the queue is empty, and a
// remove-negatives gives one read and one write-back step per held entry through
// the store's registered read port; every request ends in a response step.
module fifo_queue_negative_filter_core #(
   parameter int DEPTH = fqnf_pkg::DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  fqnf_pkg::fqnf_req_type req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output fqnf_pkg::fqnf_rsp_type rsp_payload
);
   import fqnf_pkg::*;
   `include "assert_macros.svh"

   fqnf_ctrl_type  ctrl;
   fqnf_flags_type flags;
   logic           req_fire;

   assign req_fire = req_valid && req_ready;

   fqnf_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_code  (req_payload.req_type),
      .flags     (flags),
      .ctrl      (ctrl),
      .req_ready (req_ready)
   );

   fqnf_datapath #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .req_fire    (req_fire),
      .req_payload (req_payload),
      .rsp_ready   (rsp_ready),
      .flags       (flags),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   `ASSERT_NEXT(a_busy_after_accept, req_fire, !req_ready, "request taken while busy")
   `ASSERT_ALWAYS(a_rsp_from_rsp_step, !$rose(rsp_valid) || $past(ctrl.op == OP_RSP), "response raised outside response step")
   `ASSERT_ALWAYS(a_full_empty_excl, !(flags.full && flags.empty), "queue both full and empty")

endmodule

@@ rtl/fqnf_sequencer.sv @@
// Microcode sequencer: step counter, control-word lookup and jump logic.
module fqnf_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [fqnf_pkg::REQ_W-1:0] req_code,
   input  fqnf_pkg::fqnf_flags_type flags,
   output fqnf_pkg::fqnf_ctrl_type  ctrl,
   output logic                   req_ready
);
   import fqnf_pkg::*;

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic [STEP_W-1:0] step_inc;

   assign ctrl      = ucode(step_ff);
   assign req_ready = ctrl.take_req;
   assign step_inc  = step_ff + STEP_W'(1);

   always_comb begin
      case (ctrl.cond)
         COND_NEXT:      step_in = step_inc;
         COND_JUMP:      step_in = ctrl.target;
         COND_DISPATCH:  step_in = req_valid ? dispatch(req_code) : step_ff;
         COND_EMPTY:     step_in = flags.empty ? ctrl.target : step_inc;
         COND_SCAN_DONE: step_in = flags.scan_done ? ctrl.target : step_inc;
         COND_RSP_FREE:  step_in = flags.rsp_free ? ctrl.target : step_ff;
         default:        step_in = STEP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

@@ rtl/fqnf_datapath.sv @@
// Queue datapath: entry store, head and count, filter scan and response register.
module fqnf_datapath #(
   parameter int DEPTH = fqnf_pkg::DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  fqnf_pkg::fqnf_ctrl_type  ctrl,
   input  logic                    req_fire,
   input  fqnf_pkg::fqnf_req_type   req_payload,
   input  logic                    rsp_ready,
   output fqnf_pkg::fqnf_flags_type flags,
   output logic                    rsp_valid,
   output fqnf_pkg::fqnf_rsp_type   rsp_payload
);
   import fqnf_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   logic [DATA_W-1:0]   mem [DEPTH];

   logic [IDX_W-1:0]    head_ff, head_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    kept_ff, kept_in;
   logic [DATA_W-1:0]   value_ff, value_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [DATA_W-1:0]   data_ff, data_in;
   logic [DATA_W-1:0]   rd_data_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   fqnf_rsp_type        rsp_ff, rsp_in;

   logic [IDX_W-1:0]    rd_addr;
   logic [IDX_W-1:0]    wr_addr;
   logic [DATA_W-1:0]   wr_data;
   logic                wr_en;
   logic                empty, full, rsp_free;

   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
      logic [SUM_W-1:0] sum;
      sum = {{(SUM_W - IDX_W){1'b0}}, base} + {1'b0, off};
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   assign flags.empty     = empty;
   assign flags.full      = full;
   assign flags.scan_done = (idx_ff >= count_ff);
   assign flags.rsp_free  = rsp_free;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      rd_addr = (ctrl.op == OP_FLT_RD) ? slot_of(head_ff, idx_ff) : head_ff;
      wr_en   = 1'b0;
      wr_addr = slot_of(head_ff, count_ff);
      wr_data = value_ff;
      if (ctrl.op == OP_ENQ) begin
         wr_en = !full;
      end else if (ctrl.op == OP_FLT_WR) begin
         wr_en   = !rd_data_ff[DATA_W-1];
         wr_addr = slot_of(head_ff, kept_ff);
         wr_data = rd_data_ff;
      end
   end

   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      kept_in      = kept_ff;
      value_in     = value_ff;
      status_in    = status_ff;
      data_in      = data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      case (ctrl.op)
         OP_ACCEPT: begin
            if (req_fire) begin
               value_in  = req_payload.value;
               status_in = ST_DONE;
               data_in   = '0;
            end
         end
         OP_ENQ: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_DEQ_RD: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end
         end
         OP_DEQ_TAKE: begin
            data_in  = rd_data_ff;
            head_in  = (head_ff == IDX_W'(DEPTH - 1)) ? '0 : head_ff + IDX_W'(1);
            count_in = count_ff - CNT_W'(1);
         end
         OP_FLT_INIT: begin
            idx_in  = '0;
            kept_in = '0;
         end
         OP_FLT_WR: begin
            idx_in = idx_ff + CNT_W'(1);
            if (!rd_data_ff[DATA_W-1]) begin
               kept_in = kept_ff + CNT_W'(1);
            end
         end
         OP_FLT_END: begin
            count_in = kept_ff;
         end
         OP_RSP: begin
            if (rsp_free) begin
               rsp_valid_in     = 1'b1;
               rsp_in.status    = status_ff;
               rsp_in.data      = data_ff;
               rsp_in.occupancy = OCC_W'(count_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff    <= idx_in;
      kept_ff   <= kept_in;
      value_ff  <= value_in;
      status_ff <= status_in;
      data_ff   <= data_in;
      rsp_ff    <= rsp_in;
   end

endmodule
